// ===== src/spc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

    // field widths
    localparam int RangeW  = 16;
    localparam int AngleW  = 16;
    localparam int IndexW  = 12;
    localparam int CoordW  = 32;
    localparam int OutW    = 17;
    localparam int ProdW   = 46;

    // size of the arctangent table, so the most rotation cells that can be built
    localparam int AtanEntries = 24;

    // 1/K of the rotation gain in Q30
    localparam logic [29:0] InvGainQ30 = 30'd652032874;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic signed [CoordW-1:0] ATAN_TURNS [AtanEntries] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RANGE_MIN   = 2'd0,
        REG_RANGE_MAX   = 2'd1,
        REG_START_ANGLE = 2'd2,
        REG_ANGLE_STEP  = 2'd3
    } reg_idx_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [RangeW-1:0] rng_lo;
        logic [RangeW-1:0] rng_hi;
        logic [AngleW-1:0] start_angle;
        logic [AngleW-1:0] angle_step;
    } cfg_t;

    // one point on its way through the rotation cells
    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic [1:0]               quad;
        logic                     pt_valid;
        logic [IndexW-1:0]        index;
        logic                     last;
    } cord_t;

endpackage

`default_nettype wire

// ===== src/spc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spc_front #(
    parameter int MAX_POINTS = 4096
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [spc_pkg::RangeW-1:0] range_sample,
    input  wire logic                       not_finite,
    input  wire logic [spc_pkg::IndexW-1:0] beam_index,
    input  wire logic                       last_in_scan,
    input  wire spc_pkg::cfg_t              cfg,
    output logic                            out_valid,
    output spc_pkg::cord_t                  out_data
);

    localparam logic [16:0] MaxPts = 17'(MAX_POINTS);
    localparam int ProdW = spc_pkg::ProdW;

    logic                        s1_valid_reg;
    logic                        s1_ok_reg;
    logic [spc_pkg::ProdW-1:0]   s1_prod_reg;
    logic [spc_pkg::AngleW-1:0]  s1_rot_reg;
    logic [spc_pkg::IndexW-1:0]  s1_index_reg;
    logic                        s1_last_reg;

    logic                        ok_next;
    logic [spc_pkg::ProdW-1:0]   prod_next;
    logic [31:0]                 rot_full;

    logic [spc_pkg::AngleW-1:0]  angle;
    logic [spc_pkg::AngleW-1:0]  shifted;
    logic [1:0]                  quad;
    logic [spc_pkg::AngleW-1:0]  resid;
    spc_pkg::cord_t              s2_next;
    spc_pkg::cord_t              s2_reg;
    logic                        s2_valid_reg;

    // range check and the two products
    assign ok_next   = !not_finite && (range_sample >= cfg.rng_lo)
                       && (range_sample <= cfg.rng_hi)
                       && (17'(beam_index) < MaxPts);
    assign prod_next = ProdW'(range_sample) * ProdW'(spc_pkg::InvGainQ30);
    assign rot_full  = 32'(beam_index) * 32'(cfg.angle_step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ok_reg    <= ok_next;
            s1_prod_reg  <= prod_next;
            s1_rot_reg   <= rot_full[15:0];
            s1_index_reg <= beam_index;
            s1_last_reg  <= last_in_scan;
        end
    end

    // beam angle, quadrant fold and start vector
    assign angle   = s1_rot_reg + cfg.start_angle;
    assign shifted = angle + 16'd8192;
    assign quad    = shifted[15:14];
    assign resid   = angle - {quad, 14'b0};

    always_comb begin
        s2_next          = '0;
        s2_next.x        = 32'(s1_prod_reg[ProdW-1:16]);
        s2_next.y        = '0;
        s2_next.z        = {resid, 16'b0};
        s2_next.quad     = quad;
        s2_next.pt_valid = s1_ok_reg;
        s2_next.index    = s1_index_reg;
        s2_next.last     = s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

endmodule

`default_nettype wire

// ===== src/spc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spc_cell #(
    parameter int STAGE = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire spc_pkg::cord_t in_data,
    output logic                out_valid,
    output spc_pkg::cord_t      out_data
);

    localparam logic signed [spc_pkg::CoordW-1:0] Turn = spc_pkg::ATAN_TURNS[STAGE];

    logic signed [spc_pkg::CoordW-1:0] x_in;
    logic signed [spc_pkg::CoordW-1:0] y_in;
    logic signed [spc_pkg::CoordW-1:0] z_in;
    logic signed [spc_pkg::CoordW-1:0] dx;
    logic signed [spc_pkg::CoordW-1:0] dy;
    spc_pkg::cord_t                    data_next;
    spc_pkg::cord_t                    data_reg;
    logic                              valid_reg;

    assign x_in = in_data.x;
    assign y_in = in_data.y;
    assign z_in = in_data.z;
    assign dx   = y_in >>> STAGE;
    assign dy   = x_in >>> STAGE;

    // one micro-rotation towards zero residual angle
    always_comb begin
        data_next = in_data;
        if (!z_in[spc_pkg::CoordW-1]) begin
            data_next.x = x_in - dx;
            data_next.y = y_in + dy;
            data_next.z = z_in - Turn;
        end else begin
            data_next.x = x_in + dx;
            data_next.y = y_in - dy;
            data_next.z = z_in + Turn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/spc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spc_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire spc_pkg::cord_t             in_data,
    output logic                            out_valid,
    output logic [spc_pkg::OutW-1:0]        x_mm,
    output logic [spc_pkg::OutW-1:0]        y_mm,
    output logic                            point_valid,
    output logic [spc_pkg::IndexW-1:0]      point_index,
    output logic                            point_last
);

    // round to millimetres and clamp to the output range
    function automatic logic [spc_pkg::OutW-1:0] round_sat(
        input logic signed [spc_pkg::CoordW-1:0] v
    );
        logic signed [spc_pkg::CoordW:0] ext;
        logic signed [18:0]              r;
        ext = {v[spc_pkg::CoordW-1], v} + 33'sd8192;
        r   = 19'(ext >>> 14);
        if (r > 19'sd65535) begin
            r = 19'sd65535;
        end else if (r < -19'sd65535) begin
            r = -19'sd65535;
        end
        return r[spc_pkg::OutW-1:0];
    endfunction

    logic signed [spc_pkg::CoordW-1:0] xr;
    logic signed [spc_pkg::CoordW-1:0] yr;
    logic [spc_pkg::OutW-1:0]          x_next;
    logic [spc_pkg::OutW-1:0]          y_next;
    logic                              valid_reg;
    logic [spc_pkg::OutW-1:0]          x_reg;
    logic [spc_pkg::OutW-1:0]          y_reg;
    logic                              ok_reg;
    logic [spc_pkg::IndexW-1:0]        index_reg;
    logic                              last_reg;

    // undo the quadrant fold
    always_comb begin
        unique case (in_data.quad)
            2'd0: begin
                xr = in_data.x;
                yr = in_data.y;
            end
            2'd1: begin
                xr = -in_data.y;
                yr = in_data.x;
            end
            2'd2: begin
                xr = -in_data.x;
                yr = -in_data.y;
            end
            default: begin
                xr = in_data.y;
                yr = -in_data.x;
            end
        endcase
    end

    assign x_next = in_data.pt_valid ? round_sat(xr) : '0;
    assign y_next = in_data.pt_valid ? round_sat(yr) : '0;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            ok_reg    <= in_data.pt_valid;
            index_reg <= in_data.index;
            last_reg  <= in_data.last;
        end
    end

    assign out_valid   = valid_reg;
    assign x_mm        = x_reg;
    assign y_mm        = y_reg;
    assign point_valid = ok_reg;
    assign point_index = index_reg;
    assign point_last  = last_reg;

endmodule

`default_nettype wire

// ===== src/scan_polar_to_cartesian.sv =====
// a result passes the front registers s1 and s2, the rotation cell chain and the output register
// throughput: one sample per clock while no result waits on m_tready, one rotation cell per cycle along the chain
// the whole pipeline holds while a result waits on m_tready, so s_tready is low then
// reset (aresetn low, synchronous) empties the pipeline and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module scan_polar_to_cartesian #(
    parameter int MAX_POINTS      = 4096,
    parameter int ROTATION_STAGES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // range_sample[15:0], beam_index[27:16], zero[31:28]
    input  wire logic        s_tuser,   // not_finite
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // x_mm[16:0], y_mm[33:17], point_index[45:34], zero
    output logic             m_tuser,   // point_valid
    output logic             m_tlast
);

    localparam int NumCells = (ROTATION_STAGES < spc_pkg::AtanEntries)
                              ? ROTATION_STAGES : spc_pkg::AtanEntries;

    spc_pkg::cfg_t cfg_reg;
    logic          en;

    logic                   cell_valid [NumCells+1];
    spc_pkg::cord_t         cell_data  [NumCells+1];

    logic [spc_pkg::OutW-1:0]   x_mm;
    logic [spc_pkg::OutW-1:0]   y_mm;
    logic [spc_pkg::IndexW-1:0] point_index;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rng_lo      <= 16'd0;
            cfg_reg.rng_hi      <= 16'hFFFF;
            cfg_reg.start_angle <= 16'h8000;
            cfg_reg.angle_step  <= 16'd16;
        end else if (cfg_wr_en) begin
            unique case (spc_pkg::reg_idx_t'(cfg_addr))
                spc_pkg::REG_RANGE_MIN:   cfg_reg.rng_lo      <= cfg_wdata;
                spc_pkg::REG_RANGE_MAX:   cfg_reg.rng_hi      <= cfg_wdata;
                spc_pkg::REG_START_ANGLE: cfg_reg.start_angle <= cfg_wdata;
                spc_pkg::REG_ANGLE_STEP:  cfg_reg.angle_step  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advances unless a result is waiting
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    spc_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .range_sample(s_tdata[15:0]),
        .not_finite  (s_tuser),
        .beam_index  (s_tdata[27:16]),
        .last_in_scan(s_tlast),
        .cfg         (cfg_reg),
        .out_valid   (cell_valid[0]),
        .out_data    (cell_data[0])
    );

    // chain of rotation cells
    for (genvar i = 0; i < NumCells; i++) begin : g_cell
        spc_cell #(
            .STAGE(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cell_valid[i]),
            .in_data  (cell_data[i]),
            .out_valid(cell_valid[i+1]),
            .out_data (cell_data[i+1])
        );
    end

    spc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (cell_valid[NumCells]),
        .in_data    (cell_data[NumCells]),
        .out_valid  (m_tvalid),
        .x_mm       (x_mm),
        .y_mm       (y_mm),
        .point_valid(m_tuser),
        .point_index(point_index),
        .point_last (m_tlast)
    );

    assign m_tdata = {2'b00, point_index, y_mm, x_mm};

    // invalid points carry zero coordinates
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[33:0] == 34'd0))
        else $error("invalid point with non-zero coordinates");

    // no input transfer while a result is stalled
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    // clamping keeps coordinates off the most negative code
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[16:0] != 17'h10000) && (m_tdata[33:17] != 17'h10000)))
        else $error("coordinate outside clamp range");

    // pipeline empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result present right after reset");

endmodule

`default_nettype wire
